FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: design/wsd_pkg.sv
// Package with the types, codes and the PCM conversion of the WAV sample decoder.
package wsd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    localparam logic [31:0] RST_RATE = 32'd48000;
    localparam logic [15:0] RST_CHANNELS = 16'd2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_NO_RIFF  = 4'd1;
    localparam logic [3:0] ERR_NO_WAVE  = 4'd2;
    localparam logic [3:0] ERR_SHORT    = 4'd3;
    localparam logic [3:0] ERR_ZERO     = 4'd4;
    localparam logic [3:0] ERR_UNSUPP   = 4'd5;
    localparam logic [3:0] ERR_NO_FMT   = 4'd6;
    localparam logic [3:0] ERR_EARLY    = 4'd7;
    localparam logic [3:0] ERR_MISMATCH = 4'd8;
    localparam logic [3:0] ERR_NO_FRAME = 4'd9;

    localparam logic ADDR_RATE = 1'b0;
    localparam logic ADDR_CHANNELS = 1'b1;

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSIZE,
        PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE, PH_ERR
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample_bits;
        logic [15:0] channel_index;
        logic        frame_last;
        logic        encoding;
        logic [15:0] stream_channels;
        logic [31:0] stream_rate;
        logic [15:0] frame_bytes;
        logic [31:0] data_bytes;
        logic [3:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [31:0] rate;
        logic [15:0] channels;
    } cfg_t;

    // Signed 16-bit PCM divided by 32768, as an IEEE single. The result is exact.
    function automatic logic [31:0] pcm_to_float(input logic [15:0] s);
        logic [15:0] mag;
        logic [3:0]  msb;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [38:0] sh;
        mag = s[15] ? (~s + 16'd1) : s;
        msb = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) begin
                msb = 4'(i);
            end
        end
        expo = 8'd112 + {4'd0, msb};
        sh = {23'd0, mag} << (5'd23 - {1'b0, msb});
        mant = sh[22:0];
        if (mag == 16'd0) begin
            pcm_to_float = 32'd0;
        end else begin
            pcm_to_float = {s[15], expo, mant};
        end
    endfunction

endpackage

FILE: design/wav_stream_sample_decoder_unit.sv
// Top level of the WAV stream sample decoder: one file byte per beat in, samples and headers out.
// A result is written into the result queue at the beat of the byte that completes it.
// Throughput: one byte per cycle while the result queue is not full, set by the single-pass parser logic.
// The input stalls only when both entries of the two-deep result queue are occupied.
// Reset (rst_n, asynchronous, active low) rearms the parser, empties the queue and
// loads the expected rate with 48000 and the expected channel count with 2.
module wav_stream_sample_decoder_unit
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] sample_bits,
    output logic [15:0] channel_index,
    output logic        frame_last,
    output logic        encoding,
    output logic [15:0] stream_channels,
    output logic [31:0] stream_rate,
    output logic [15:0] frame_bytes,
    output logic [31:0] data_bytes,
    output logic [3:0]  error_code
);

    cfg_t    cfg;
    logic    beat;
    logic    res_valid;
    logic    full;
    result_t res;
    result_t head;

    // The register port never waits.
    assign pready = 1'b1;

    wsd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // A byte beat is taken whenever the result queue has room; the stall is a
    // registered signal and does not depend on the output side combinationally.
    assign in_stall = full;
    assign beat = in_valid && !in_stall;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Each byte yields at most one result, which is queued on the same edge.
    wsd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat && res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head)
    );

    assign kind            = head.kind;
    assign sample_bits     = head.sample_bits;
    assign channel_index   = head.channel_index;
    assign frame_last      = head.frame_last;
    assign encoding        = head.encoding;
    assign stream_channels = head.stream_channels;
    assign stream_rate     = head.stream_rate;
    assign frame_bytes     = head.frame_bytes;
    assign data_bytes      = head.data_bytes;
    assign error_code      = head.error_code;

endmodule

FILE: design/wsd_cfg_regs.sv
// APB register file holding the expected rate and channel count.
module wsd_cfg_regs
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    logic [31:0] rate_reg;
    logic [15:0] chan_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RST_RATE;
            chan_reg <= RST_CHANNELS;
        end
        else if (wr_en)
        begin
            if (paddr[2] == ADDR_RATE)
            begin
                rate_reg <= pwdata;
            end
            else
            begin
                chan_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == ADDR_CHANNELS) ? {16'd0, chan_reg} : rate_reg;
    assign cfg = '{rate: rate_reg, channels: chan_reg};

endmodule

FILE: design/wsd_parser.sv
// Byte-wise RIFF/WAVE parser state and the single-pass next-state and result logic.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat,
    input  logic [7:0] file_byte,
    input  logic       end_of_file,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] len_reg, len_next;
    logic [3:0]  foff_reg, foff_next;
    logic [15:0] fc_reg, fc_next;
    logic [15:0] sw_reg, sw_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] ba_reg, ba_next;
    logic        seen_reg, seen_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] boff_reg, boff_next;
    logic [15:0] cur_reg, cur_next;
    logic        isfmt_reg, isfmt_next;
    logic        isdata_reg, isdata_next;

    logic [31:0] wd;
    logic        fail;
    logic [3:0]  fcode;
    logic        is_float;
    logic [17:0] ch_bytes;
    logic [16:0] boff_inc;
    logic [31:0] fskip;

    always_comb
    begin
        phase_next = phase_reg; pos_next = pos_reg; asm_next = asm_reg;
        skip_next = skip_reg; len_next = len_reg; foff_next = foff_reg;
        fc_next = fc_reg; sw_next = sw_reg; ch_next = ch_reg; rate_next = rate_reg;
        ba_next = ba_reg; seen_next = seen_reg; rem_next = rem_reg; boff_next = boff_reg;
        cur_next = cur_reg; isfmt_next = isfmt_reg; isdata_next = isdata_reg;
        res_valid = 1'b0;
        res = '0;
        fail = 1'b0;
        fcode = ERR_NONE;
        fskip = len_reg - FMT_MIN_LEN;
        wd = ((pos_reg == 2'd0) ? 32'd0 : asm_reg)
             | ({24'd0, file_byte} << {pos_reg, 3'b000});
        is_float = (fc_reg == FMT_FLOAT);
        ch_bytes = is_float ? {ch_reg, 2'b00} : {1'b0, ch_reg, 1'b0};
        boff_inc = {1'b0, boff_reg} + 17'd1;

        if (beat)
        begin
            case (phase_reg)
                PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSIZE:
                begin
                    asm_next = wd;
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        case (phase_reg)
                            PH_RIFF:
                            begin
                                if (wd != TAG_RIFF)
                                begin
                                    fail = 1'b1; fcode = ERR_NO_RIFF;
                                end
                                else
                                begin
                                    phase_next = PH_RSIZE;
                                end
                            end
                            PH_RSIZE: phase_next = PH_WAVE;
                            PH_WAVE:
                            begin
                                if (wd != TAG_WAVE)
                                begin
                                    fail = 1'b1; fcode = ERR_NO_WAVE;
                                end
                                else
                                begin
                                    phase_next = PH_CHID;
                                end
                            end
                            PH_CHID:
                            begin
                                isfmt_next = (wd == TAG_FMT);
                                isdata_next = (wd == TAG_DATA);
                                phase_next = PH_CHSIZE;
                            end
                            default:
                            begin
                                len_next = wd;
                                if (isfmt_reg)
                                begin
                                    if (wd < FMT_MIN_LEN)
                                    begin
                                        fail = 1'b1; fcode = ERR_SHORT;
                                    end
                                    else
                                    begin
                                        foff_next = 4'd0;
                                        phase_next = PH_FMT;
                                    end
                                end
                                else if (isdata_reg)
                                begin
                                    if (!seen_reg || ba_reg == 16'd0)
                                    begin
                                        fail = 1'b1; fcode = ERR_NO_FMT;
                                    end
                                    else if (wd < {16'd0, ba_reg})
                                    begin
                                        fail = 1'b1; fcode = ERR_NO_FRAME;
                                    end
                                    else if (rate_reg != cfg.rate || ch_reg != cfg.channels)
                                    begin
                                        fail = 1'b1; fcode = ERR_MISMATCH;
                                    end
                                    else
                                    begin
                                        rem_next = wd;
                                        boff_next = 16'd0;
                                        cur_next = 16'd0;
                                        pos_next = 2'd0;
                                        phase_next = PH_DATA;
                                        res_valid = 1'b1;
                                        res.kind = KIND_ACCEPT;
                                        res.encoding = is_float;
                                        res.stream_channels = ch_reg;
                                        res.stream_rate = rate_reg;
                                        res.frame_bytes = ba_reg;
                                        res.data_bytes = wd;
                                    end
                                end
                                else
                                begin
                                    skip_next = wd;
                                    if (wd != 32'd0)
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                    else
                                    begin
                                        phase_next = PH_CHID;
                                    end
                                end
                            end
                        endcase
                    end
                end
                PH_FMT:
                begin
                    case (foff_reg)
                        4'd0:  fc_next = {8'd0, file_byte};
                        4'd1:  fc_next = {file_byte, fc_reg[7:0]};
                        4'd2:  ch_next = {8'd0, file_byte};
                        4'd3:  ch_next = {file_byte, ch_reg[7:0]};
                        4'd4:  rate_next = {24'd0, file_byte};
                        4'd5:  rate_next = {16'd0, file_byte, rate_reg[7:0]};
                        4'd6:  rate_next = {8'd0, file_byte, rate_reg[15:0]};
                        4'd7:  rate_next = {file_byte, rate_reg[23:0]};
                        4'd12: ba_next = {8'd0, file_byte};
                        4'd13: ba_next = {file_byte, ba_reg[7:0]};
                        4'd14: sw_next = {8'd0, file_byte};
                        4'd15: sw_next = {file_byte, sw_reg[7:0]};
                        default: ;
                    endcase
                    foff_next = foff_reg + 4'd1;
                    if (foff_reg == 4'd15)
                    begin
                        skip_next = fskip;
                        if (ch_reg == 16'd0 || rate_reg == 32'd0 || ba_reg == 16'd0)
                        begin
                            fail = 1'b1; fcode = ERR_ZERO;
                        end
                        else if (!((fc_reg == FMT_PCM && sw_next == 16'd16)
                                   || (fc_reg == FMT_FLOAT && sw_next == 16'd32)))
                        begin
                            fail = 1'b1; fcode = ERR_UNSUPP;
                        end
                        else if (ch_bytes > {2'd0, ba_reg})
                        begin
                            fail = 1'b1; fcode = ERR_UNSUPP;
                        end
                        else
                        begin
                            seen_next = 1'b1;
                            if (fskip != 32'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if (len_reg[0])
                            begin
                                phase_next = PH_PAD;
                            end
                            else
                            begin
                                phase_next = PH_CHID;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = len_reg[0] ? PH_PAD : PH_CHID;
                    end
                end
                PH_PAD: phase_next = PH_CHID;
                PH_DATA:
                begin
                    if ({2'd0, boff_reg} < ch_bytes)
                    begin
                        asm_next = wd;
                        pos_next = pos_reg + 2'd1;
                        if (pos_reg == (is_float ? 2'd3 : 2'd1))
                        begin
                            res_valid = 1'b1;
                            res.kind = KIND_SAMPLE;
                            res.sample_bits = is_float ? wd : pcm_to_float(wd[15:0]);
                            res.channel_index = cur_reg;
                            res.frame_last = (({1'b0, cur_reg} + 17'd1) == {1'b0, ch_reg});
                            cur_next = cur_reg + 16'd1;
                            pos_next = 2'd0;
                        end
                    end
                    boff_next = boff_inc[15:0];
                    rem_next = rem_reg - 32'd1;
                    if (boff_inc >= {1'b0, ba_reg})
                    begin
                        boff_next = 16'd0;
                        cur_next = 16'd0;
                        pos_next = 2'd0;
                        if (rem_next < {16'd0, ba_reg})
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase

            if (end_of_file && !res_valid && !fail && phase_next <= PH_PAD)
            begin
                fail = 1'b1; fcode = ERR_EARLY;
            end

            if (fail)
            begin
                phase_next = PH_ERR;
                res_valid = 1'b1;
                res = '0;
                res.kind = KIND_REJECT;
                res.stream_channels = ch_next;
                res.stream_rate = rate_next;
                res.frame_bytes = ba_next;
                res.error_code = fcode;
            end

            if (end_of_file)
            begin
                phase_next = PH_RIFF; pos_next = 2'd0; asm_next = 32'd0;
                skip_next = 32'd0; len_next = 32'd0; foff_next = 4'd0;
                fc_next = 16'd0; sw_next = 16'd0; ch_next = 16'd0; rate_next = 32'd0;
                ba_next = 16'd0; seen_next = 1'b0; rem_next = 32'd0; boff_next = 16'd0;
                cur_next = 16'd0; isfmt_next = 1'b0; isdata_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF; pos_reg <= '0; asm_reg <= '0; skip_reg <= '0;
            len_reg <= '0; foff_reg <= '0; fc_reg <= '0; sw_reg <= '0; ch_reg <= '0;
            rate_reg <= '0; ba_reg <= '0; seen_reg <= 1'b0; rem_reg <= '0;
            boff_reg <= '0; cur_reg <= '0; isfmt_reg <= 1'b0; isdata_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; asm_reg <= asm_next;
            skip_reg <= skip_next; len_reg <= len_next; foff_reg <= foff_next;
            fc_reg <= fc_next; sw_reg <= sw_next; ch_reg <= ch_next;
            rate_reg <= rate_next; ba_reg <= ba_next; seen_reg <= seen_next;
            rem_reg <= rem_next; boff_reg <= boff_next; cur_reg <= cur_next;
            isfmt_reg <= isfmt_next; isdata_reg <= isdata_next;
        end
    end

endmodule

FILE: design/wsd_result_fifo.sv
// Two-entry result queue that decouples the parser from output stalls.
module wsd_result_fifo
    import wsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    result_t     mem [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full = (cnt_reg == 2'd2);
    assign pop = out_valid && !out_stall;
    assign out_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/wsd_checker.sv
// Port-level checker for the WAV sample decoder and its bind statement.
`include "assert_macros.svh"
module wsd_checker
    import wsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [3:0]  error_code,
    input logic [31:0] data_bytes
);

    logic sample_beat;
    logic reject_beat;

    assign sample_beat = out_valid && (kind == KIND_SAMPLE);
    assign reject_beat = out_valid && (kind == KIND_REJECT);

    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
    `ASSERT_CLK(a_kind_ok, out_valid |-> kind <= KIND_REJECT, "bad kind")
    `ASSERT_CLK(a_reject_code, reject_beat |-> error_code != ERR_NONE, "reject without cause")
    `ASSERT_CLK(a_sample_clean, sample_beat |-> error_code == ERR_NONE && data_bytes == '0, "dirty sample")

endmodule

bind wav_stream_sample_decoder_unit wsd_checker u_wsd_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the WAV stream sample decoder: byte stream in, samples and headers out.
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    // Run limits.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 85;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  file_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [31:0] sample_bits;
    logic [15:0] channel_index;
    logic        frame_last;
    logic        encoding;
    logic [15:0] stream_channels;
    logic [31:0] stream_rate;
    logic [15:0] frame_bytes;
    logic [31:0] data_bytes;
    logic [3:0]  error_code;

    wav_stream_sample_decoder_unit uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .file_byte(file_byte), .end_of_file(end_of_file),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .sample_bits(sample_bits), .channel_index(channel_index),
        .frame_last(frame_last), .encoding(encoding),
        .stream_channels(stream_channels), .stream_rate(stream_rate),
        .frame_bytes(frame_bytes), .data_bytes(data_bytes), .error_code(error_code)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Expected results, oldest first, and the bookkeeping of the run.
    result_t     pending_results[$];
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned samples_seen;
    int unsigned headers_seen;
    int unsigned rejects_seen;
    int unsigned files_sent;
    int unsigned error_count;
    bit          quiet_sender;
    bit          quiet_receiver;

    // The byte stream of the file being sent.
    logic [7:0]  file_q[$];

    // ------------------------------------------------------------------
    // Parser mirror: its own copy of the registers and the parse state.
    // ------------------------------------------------------------------
    logic [31:0] want_rate;
    logic [15:0] want_channels;

    phase_t      step_phase;
    logic [31:0] byte_pos;
    logic [31:0] word_acc;
    logic [31:0] skip_left;
    logic [31:0] chunk_len;
    logic [31:0] fmt_pos;
    logic [31:0] fmt_code;
    logic [31:0] width_bits;
    logic [31:0] chan_count;
    logic [31:0] rate_seen;
    logic [31:0] align_seen;
    bit          fmt_valid;
    logic [31:0] data_left;
    logic [31:0] frame_pos;
    logic [31:0] chan_now;
    logic [31:0] chunk_tag;

    function automatic void rearm_parser();
        step_phase = PH_RIFF;
        byte_pos   = '0;
        word_acc   = '0;
        skip_left  = '0;
        chunk_len  = '0;
        fmt_pos    = '0;
        fmt_code   = '0;
        width_bits = '0;
        chan_count = '0;
        rate_seen  = '0;
        align_seen = '0;
        fmt_valid  = 1'b0;
        data_left  = '0;
        frame_pos  = '0;
        chan_now   = '0;
        chunk_tag  = '0;
    endfunction

    // Gathers a little-endian word; true when its fourth byte has arrived.
    function automatic bit gather_word(input logic [7:0] b);
        if (byte_pos == 0) word_acc = '0;
        word_acc = word_acc | ({24'd0, b} << (8 * (byte_pos & 3)));
        byte_pos = (byte_pos + 1) & 7;
        if (byte_pos >= 4) begin
            byte_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit reject_header(input logic [3:0] code, inout result_t r);
        step_phase        = PH_ERR;
        r                 = '0;
        r.kind            = KIND_REJECT;
        r.stream_channels = chan_count[15:0];
        r.stream_rate     = rate_seen;
        r.frame_bytes     = align_seen[15:0];
        r.error_code      = code;
        return 1'b1;
    endfunction

    function automatic void leave_chunk();
        if (skip_left != 0) step_phase = PH_SKIP;
        else if (chunk_len[0]) step_phase = PH_PAD;
        else step_phase = PH_CHID;
    endfunction

    // Signed PCM over 32768 as single-precision bits, by normalising the magnitude.
    function automatic logic [31:0] pcm_bits(input logic [15:0] s);
        logic [16:0] mag;
        int          top;
        logic [39:0] wide;
        if (s == 16'd0) return 32'd0;
        mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        top = 16;
        while (!mag[top]) top--;
        wide = {23'd0, mag} << (23 - top);
        return {s[15], 8'(112 + top), wide[22:0]};
    endfunction

    // Advances the mirror by one byte; returns 1 with the result it causes.
    function automatic bit decode_byte(input logic [7:0] b, input bit eof, output result_t r);
        bit          got;
        logic [31:0] width_bytes;
        logic [31:0] frames;
        got = 1'b0;
        r = '0;
        width_bytes = (fmt_code == {16'd0, FMT_FLOAT}) ? 4 : 2;
        case (step_phase)
            PH_RIFF: begin
                if (gather_word(b)) begin
                    if (word_acc != TAG_RIFF) got = reject_header(ERR_NO_RIFF, r);
                    else step_phase = PH_RSIZE;
                end
            end
            PH_RSIZE: begin
                if (gather_word(b)) step_phase = PH_WAVE;
            end
            PH_WAVE: begin
                if (gather_word(b)) begin
                    if (word_acc != TAG_WAVE) got = reject_header(ERR_NO_WAVE, r);
                    else step_phase = PH_CHID;
                end
            end
            PH_CHID: begin
                if (gather_word(b)) begin
                    chunk_tag  = word_acc;
                    step_phase = PH_CHSIZE;
                end
            end
            PH_CHSIZE: begin
                if (gather_word(b)) begin
                    chunk_len = word_acc;
                    if (chunk_tag == TAG_FMT) begin
                        if (chunk_len < FMT_MIN_LEN) got = reject_header(ERR_SHORT, r);
                        else begin
                            fmt_pos    = '0;
                            step_phase = PH_FMT;
                        end
                    end else if (chunk_tag == TAG_DATA) begin
                        if (!fmt_valid || align_seen == 0) begin
                            got = reject_header(ERR_NO_FMT, r);
                        end else begin
                            frames = chunk_len / align_seen;
                            if (frames == 0) got = reject_header(ERR_NO_FRAME, r);
                            else if (rate_seen != want_rate
                                     || chan_count != {16'd0, want_channels})
                                got = reject_header(ERR_MISMATCH, r);
                            else begin
                                data_left         = frames * align_seen;
                                frame_pos         = '0;
                                chan_now          = '0;
                                byte_pos          = '0;
                                step_phase        = PH_DATA;
                                r.kind            = KIND_ACCEPT;
                                r.encoding        = (fmt_code == {16'd0, FMT_FLOAT});
                                r.stream_channels = chan_count[15:0];
                                r.stream_rate     = rate_seen;
                                r.frame_bytes     = align_seen[15:0];
                                r.data_bytes      = chunk_len;
                                got = 1'b1;
                            end
                        end
                    end else begin
                        skip_left = chunk_len;
                        leave_chunk();
                    end
                end
            end
            PH_FMT: begin
                if (fmt_pos < 2)
                    fmt_code = (fmt_pos == 0) ? {24'd0, b} : (fmt_code | ({24'd0, b} << 8));
                else if (fmt_pos < 4)
                    chan_count = (fmt_pos == 2) ? {24'd0, b}
                                                : (chan_count | ({24'd0, b} << 8));
                else if (fmt_pos < 8)
                    rate_seen = (fmt_pos == 4) ? {24'd0, b}
                                               : (rate_seen | ({24'd0, b} << (8 * (fmt_pos - 4))));
                else if (fmt_pos >= 12 && fmt_pos < 14)
                    align_seen = (fmt_pos == 12) ? {24'd0, b}
                                                 : (align_seen | ({24'd0, b} << 8));
                else if (fmt_pos >= 14)
                    width_bits = (fmt_pos == 14) ? {24'd0, b}
                                                 : (width_bits | ({24'd0, b} << 8));
                fmt_pos = fmt_pos + 1;
                if (fmt_pos >= FMT_MIN_LEN) begin
                    skip_left   = chunk_len - FMT_MIN_LEN;
                    width_bytes = (fmt_code == {16'd0, FMT_FLOAT}) ? 4 : 2;
                    if (chan_count == 0 || rate_seen == 0 || align_seen == 0)
                        got = reject_header(ERR_ZERO, r);
                    else if (!((fmt_code == {16'd0, FMT_PCM} && width_bits == 16)
                             || (fmt_code == {16'd0, FMT_FLOAT} && width_bits == 32)))
                        got = reject_header(ERR_UNSUPP, r);
                    else if (chan_count * width_bytes > align_seen)
                        got = reject_header(ERR_UNSUPP, r);
                    else begin
                        fmt_valid = 1'b1;
                        leave_chunk();
                    end
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) step_phase = chunk_len[0] ? PH_PAD : PH_CHID;
            end
            PH_PAD: step_phase = PH_CHID;
            PH_DATA: begin
                if (frame_pos < chan_count * width_bytes) begin
                    if (byte_pos == 0) word_acc = '0;
                    word_acc = word_acc | ({24'd0, b} << (8 * (byte_pos & 3)));
                    byte_pos = byte_pos + 1;
                    if (byte_pos >= width_bytes) begin
                        r.kind          = KIND_SAMPLE;
                        r.sample_bits   = (width_bytes == 2) ? pcm_bits(word_acc[15:0])
                                                             : word_acc;
                        r.channel_index = chan_now[15:0];
                        r.frame_last    = (chan_now + 1 == chan_count);
                        got = 1'b1;
                        chan_now = chan_now + 1;
                        byte_pos = '0;
                    end
                end
                frame_pos = frame_pos + 1;
                if (frame_pos >= align_seen) begin
                    frame_pos = '0;
                    chan_now  = '0;
                    byte_pos  = '0;
                end
                data_left = data_left - 1;
                if (data_left == 0) step_phase = PH_DONE;
            end
            default: ;
        endcase
        if (eof) begin
            if (!got && step_phase <= PH_PAD) got = reject_header(ERR_EARLY, r);
            rearm_parser();
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes over the register port.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only once the block has drained; the extra wait after that
    // covers bytes still in flight that cause no result.
    task automatic set_limits(input logic [31:0] rate, input logic [15:0] chans);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(3'(4 * ADDR_RATE), rate);
        write_reg(3'(4 * ADDR_CHANNELS), {16'd0, chans});
        want_rate     = rate;
        want_channels = chans;
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat per byte, with random idle cycles.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input bit eof, input bit typed,
                             input result_t typed_result);
        bit      stalled;
        bit      got;
        result_t predicted;
        while (!quiet_sender && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        file_byte   <= b;
        end_of_file <= eof;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        // The beat was taken at this edge.
        bytes_sent++;
        got = decode_byte(b, eof, predicted);
        if (typed) pending_results.push_back(typed_result);
        else if (got) pending_results.push_back(predicted);
    endtask

    task automatic put16(input logic [15:0] v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    // Sample payload with a bias towards the extremes of the PCM and float ranges.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds one file into file_q. Most files are well formed with random content;
    // the rest carry one deliberate defect, or are plain noise.
    task automatic build_file();
        int unsigned flavour;
        int unsigned defect;
        logic [15:0] code;
        int unsigned chans;
        logic [31:0] rate;
        int unsigned width;
        int unsigned align;
        int unsigned fmt_len;
        int unsigned frames;
        int unsigned body;
        int unsigned junk_len;
        bit          skip_fmt;
        file_q.delete();
        flavour = $urandom_range(0, 99);
        if (flavour < 5) begin
            repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom));
            return;
        end
        defect   = (flavour < 72) ? 99 : $urandom_range(0, 6);
        code     = ($urandom_range(0, 1) != 0) ? FMT_FLOAT : FMT_PCM;
        width    = (code == FMT_FLOAT) ? 32 : 16;
        chans    = (want_channels <= 3 && $urandom_range(0, 9) != 0)
                   ? want_channels : $urandom_range(1, 3);
        rate     = ($urandom_range(0, 9) != 0) ? want_rate : $urandom;
        align    = chans * width / 8;
        if ($urandom_range(0, 3) == 0) align += $urandom_range(1, 3);
        fmt_len  = 16;
        if ($urandom_range(0, 3) == 0) fmt_len += $urandom_range(1, 3);
        skip_fmt = 1'b0;
        case (defect)
            0: fmt_len = $urandom_range(0, 15);
            1: begin
                case ($urandom_range(0, 2))
                    0: chans = 0;
                    1: rate = 0;
                    default: align = 0;
                endcase
            end
            2: begin
                if ($urandom_range(0, 1) != 0) code = 16'($urandom_range(0, 5));
                else width = ($urandom_range(0, 1) != 0) ? 24 : 8;
            end
            3: skip_fmt = 1'b1;
            4: align = chans * width / 8 - 1;
            default: ;
        endcase
        put32(TAG_RIFF);
        put32($urandom);
        put32(TAG_WAVE);
        if ($urandom_range(0, 2) == 0) begin
            junk_len = $urandom_range(0, 5);
            put32($urandom);
            put32(junk_len);
            repeat (junk_len + (junk_len % 2)) file_q.push_back(8'($urandom));
        end
        if (!skip_fmt) begin
            put32(TAG_FMT);
            put32(fmt_len);
            if (fmt_len >= 16) begin
                put16(code);
                put16(16'(chans));
                put32(rate);
                put32(rate * align);
                put16(16'(align));
                put16(16'(width));
                repeat (fmt_len - 16 + (fmt_len % 2)) file_q.push_back(8'($urandom));
            end
        end
        frames = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        body   = frames * align + ((align > 1) ? $urandom_range(0, align - 1) : 0);
        put32(TAG_DATA);
        put32(body);
        // Occasionally the file ends inside the data, or runs on past it.
        if ($urandom_range(0, 6) == 0) body = $urandom_range(0, body);
        repeat (body) file_q.push_back(payload_byte());
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
        if (defect == 5) file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        if (defect == 6) file_q = file_q[0 : $urandom_range(0, file_q.size() - 1)];
    endtask

    task automatic send_file();
        result_t unused;
        unused = '0;
        foreach (file_q[i]) send_beat(file_q[i], i == file_q.size() - 1, 1'b0, unused);
        files_sent++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the field-by-field check.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        out_stall   <= !quiet_receiver && ($urandom_range(0, 99) < 6);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Outputs and the stall are steady from the falling edge to the next rising
    // edge, so a beat seen here is the one accepted at that rising edge.
    always @(negedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, kind %0d error %0d", $time, kind, error_code);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                case (want.kind)
                    KIND_SAMPLE: samples_seen++;
                    KIND_ACCEPT: headers_seen++;
                    default: rejects_seen++;
                endcase
                report_field("kind", 32'(want.kind), 32'(kind));
                report_field("sample_bits", want.sample_bits, sample_bits);
                report_field("channel_index", 32'(want.channel_index), 32'(channel_index));
                report_field("frame_last", 32'(want.frame_last), 32'(frame_last));
                report_field("encoding", 32'(want.encoding), 32'(encoding));
                report_field("stream_channels", 32'(want.stream_channels),
                             32'(stream_channels));
                report_field("stream_rate", want.stream_rate, stream_rate);
                report_field("frame_bytes", 32'(want.frame_bytes), 32'(frame_bytes));
                report_field("data_bytes", want.data_bytes, data_bytes);
                report_field("error_code", 32'(want.error_code), 32'(error_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: header faults whose results can be read off directly.
    // A typed row carries its own expectation; the others go to the mirror.
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        bit         eof;
        bit         typed;
        logic [1:0] want_kind;
        logic [3:0] want_error;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;
    directed_row_t directed_rows[DIRECTED_ROWS] = '{
        '{8'h52, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h49, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h46, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h58, 1'b0, 1'b1, KIND_REJECT, ERR_NO_RIFF},
        '{8'hFF, 1'b1, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h52, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h49, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h00, 1'b1, 1'b1, KIND_REJECT, ERR_EARLY},
        '{8'h52, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h49, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h46, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h46, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h57, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h41, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h56, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE},
        '{8'h58, 1'b0, 1'b1, KIND_REJECT, ERR_NO_WAVE},
        '{8'h00, 1'b1, 1'b0, KIND_SAMPLE, ERR_NONE}
    };

    initial begin
        result_t     typed_result;
        int unsigned phase_start;
        int unsigned settle;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        file_byte      = '0;
        end_of_file    = 1'b0;
        out_stall      = 1'b0;
        cycle_count    = 0;
        bytes_sent     = 0;
        results_seen   = 0;
        samples_seen   = 0;
        headers_seen   = 0;
        rejects_seen   = 0;
        files_sent     = 0;
        error_count    = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        want_rate      = RST_RATE;
        want_channels  = RST_CHANNELS;
        rearm_parser();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed header faults under the reset register values.
        foreach (directed_rows[i]) begin
            typed_result            = '0;
            typed_result.kind       = directed_rows[i].want_kind;
            typed_result.error_code = directed_rows[i].want_error;
            send_beat(directed_rows[i].b, directed_rows[i].eof,
                      directed_rows[i].typed, typed_result);
        end

        // Hold the sender back until everything so far has come out.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);

        // Random files across several register settings, the extremes among them.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: ;
                1: set_limits(32'd1, 16'd1);
                2: set_limits(32'hFFFF_FFFF, 16'hFFFF);
                3: set_limits($urandom, 16'($urandom_range(1, 3)));
                default: set_limits(32'd44100, 16'd3);
            endcase
            // The second setting runs with no idling on either side.
            quiet_sender   = (phase == 1);
            quiet_receiver = (phase == 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_file();
                send_file();
            end
            quiet_sender   = 1'b0;
            quiet_receiver = 1'b0;
        end
        in_valid    <= 1'b0;
        end_of_file <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        settle = 0;
        while (settle < 10) begin
            @(posedge clk);
            settle++;
        end

        $display("Sent %0d bytes in %0d files over five register settings.",
                 bytes_sent, files_sent);
        $display("Checked %0d samples, %0d accepted and %0d rejected headers.",
                 samples_seen, headers_seen, rejects_seen);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
